// ----- sv/rbs_pkg.sv -----
package rbs_pkg;

	localparam int COORD_W = 32;
	localparam int DIFF_W = COORD_W + 1;
	localparam int VEL_W = 48;
	localparam int QUEUE_DEPTH = 2;
	localparam logic [31:0] SMOOTHING_SQ_RESET = 32'd16777;
	localparam logic signed [VEL_W-1:0] SAT_MAX = 48'sh7FFF_FFFF_FFFF;
	localparam logic signed [VEL_W-1:0] SAT_MIN = 48'sh8000_0000_0000;

	typedef struct packed {
		logic signed [DIFF_W-1:0]  dx;
		logic signed [DIFF_W-1:0]  dy;
		logic signed [DIFF_W-1:0]  dz;
		logic signed [COORD_W-1:0] wx;
		logic signed [COORD_W-1:0] wy;
		logic signed [COORD_W-1:0] wz;
		logic                      first;
		logic                      last;
	} item_t;

endpackage

// ----- sv/rbs_front.sv -----
module rbs_front
	import rbs_pkg::*;
(
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      push,
	output logic                      full,
	input  logic signed [COORD_W-1:0] target_x,
	input  logic signed [COORD_W-1:0] target_y,
	input  logic signed [COORD_W-1:0] target_z,
	input  logic signed [COORD_W-1:0] src_x,
	input  logic signed [COORD_W-1:0] src_y,
	input  logic signed [COORD_W-1:0] src_z,
	input  logic signed [COORD_W-1:0] weight_x,
	input  logic signed [COORD_W-1:0] weight_y,
	input  logic signed [COORD_W-1:0] weight_z,
	input  logic                      first_source,
	input  logic                      last_source,
	output logic                      item_valid,
	output item_t                     item,
	input  logic                      item_ready
);

	logic  valid_s1;
	item_t item_s1;
	logic  take;

	assign full = valid_s1 && !item_ready;
	assign take = push && !full;
	assign item_valid = valid_s1;
	assign item = item_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (take) begin
			valid_s1 <= 1'b1;
		end else if (item_ready) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			item_s1.dx    <= {target_x[COORD_W-1], target_x} - {src_x[COORD_W-1], src_x};
			item_s1.dy    <= {target_y[COORD_W-1], target_y} - {src_y[COORD_W-1], src_y};
			item_s1.dz    <= {target_z[COORD_W-1], target_z} - {src_z[COORD_W-1], src_z};
			item_s1.wx    <= weight_x;
			item_s1.wy    <= weight_y;
			item_s1.wz    <= weight_z;
			item_s1.first <= first_source;
			item_s1.last  <= last_source;
		end
	end

endmodule

// ----- sv/rbs_fifo.sv -----
module rbs_fifo
	import rbs_pkg::*;
(
	input  logic  clk,
	input  logic  arst_n,
	input  logic  wr_valid,
	output logic  wr_ready,
	input  item_t wr_data,
	output logic  rd_valid,
	input  logic  rd_take,
	output item_t rd_data
);

	localparam int AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

	item_t         mem_q [QUEUE_DEPTH];
	logic [AW-1:0] wr_ptr_q;
	logic [AW-1:0] rd_ptr_q;
	logic [AW:0]   count_q;
	logic          wr_en;
	logic          rd_en;

	assign wr_ready = (count_q != (AW+1)'(QUEUE_DEPTH));
	assign rd_valid = (count_q != '0);
	assign wr_en = wr_valid && wr_ready;
	assign rd_en = rd_take && rd_valid;
	assign rd_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (wr_en) begin
				wr_ptr_q <= (wr_ptr_q == AW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (rd_en) begin
				rd_ptr_q <= (rd_ptr_q == AW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (wr_en && !rd_en) begin
				count_q <= count_q + 1'b1;
			end else if (rd_en && !wr_en) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

endmodule

// ----- sv/rbs_back.sv -----
module rbs_back
	import rbs_pkg::*;
#(
	parameter int FRAC_BITS = 24
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic [31:0]             smoothing_sq,
	input  logic                    item_valid,
	input  item_t                   item,
	output logic                    item_take,
	output logic                    empty,
	input  logic                    pop,
	output logic signed [VEL_W-1:0] vel_x,
	output logic signed [VEL_W-1:0] vel_y,
	output logic signed [VEL_W-1:0] vel_z
);

	localparam int R2W = ((FRAC_BITS > 32) ? 32 + FRAC_BITS : 64) + 2;
	localparam int XW = R2W + 2 * FRAC_BITS;
	localparam int SW = (XW + 1) / 2;
	localparam int XPW = 2 * SW;
	localparam int DENW = R2W + SW;
	localparam int CW = 66;
	localparam int MW = CW - 1;
	localparam int NW = MW + 3 * FRAC_BITS;
	localparam int CNTW = $clog2(NW + 1);

	typedef enum logic [6:0] {
		ST_IDLE  = 7'b0000001,
		ST_SQ    = 7'b0000010,
		ST_SQRT  = 7'b0000100,
		ST_MUL   = 7'b0001000,
		ST_CROSS = 7'b0010000,
		ST_DIV   = 7'b0100000,
		ST_EMIT  = 7'b1000000
	} state_t;

	state_t                    state_q;
	item_t                     item_q;
	logic [CNTW-1:0]           cnt_q;
	logic [R2W-1:0]            r2_q;
	logic [XPW-1:0]            x_q;
	logic [SW-1:0]             root_q;
	logic [SW+1:0]             srem_q;
	logic [DENW-1:0]           den_q;
	logic signed [64:0]        p1_q;
	logic signed [CW-1:0]      c_q [3];
	logic [1:0]                comp_q;
	logic [NW-1:0]             n_q;
	logic [DENW-1:0]           rem_q;
	logic [VEL_W-1:0]          q_q;
	logic                      huge_q;
	logic                      cpos_q;
	logic                      czero_q;
	logic signed [VEL_W-1:0]   sum_q [3];
	logic                      out_valid_q;
	logic signed [VEL_W-1:0]   vel_q [3];

	logic signed [DIFF_W-1:0]  sq_d;
	logic [31:0]               sq_mag;
	logic [63:0]               sq_prod;
	logic [R2W-1:0]            r2_next;
	logic [SW+3:0]             srt_sh;
	logic [SW+3:0]             srt_trial;
	logic signed [DIFF_W-1:0]  mul_a;
	logic signed [COORD_W-1:0] mul_b;
	logic signed [64:0]        prod;
	logic [1:0]                ld_idx;
	logic signed [CW-1:0]      c_sel;
	logic [MW-1:0]             c_mag;
	logic [DENW:0]             div_sh;
	logic                      div_ge;
	logic                      huge_all;
	logic [VEL_W-2:0]          q_mag;
	logic signed [VEL_W-1:0]   term;
	logic signed [VEL_W:0]     sum_wide;
	logic signed [VEL_W-1:0]   sum_new;
	logic                      last_step;

	assign item_take = (state_q == ST_IDLE) && item_valid;
	assign empty = !out_valid_q;
	assign vel_x = vel_q[0];
	assign vel_y = vel_q[1];
	assign vel_z = vel_q[2];

	always_comb begin
		case (cnt_q[1:0])
			2'd0:    sq_d = item_q.dx;
			2'd1:    sq_d = item_q.dy;
			default: sq_d = item_q.dz;
		endcase
		sq_mag = sq_d[DIFF_W-1] ? 32'(-sq_d) : sq_d[31:0];
	end
	assign sq_prod = sq_mag * sq_mag;
	assign r2_next = r2_q + R2W'(sq_prod);

	assign srt_sh = {srem_q, x_q[XPW-1 -: 2]};
	assign srt_trial = {2'b00, root_q, 2'b01};

	always_comb begin
		case (cnt_q[2:0])
			3'd0:    begin mul_a = item_q.dy; mul_b = item_q.wz; end
			3'd1:    begin mul_a = item_q.dz; mul_b = item_q.wy; end
			3'd2:    begin mul_a = item_q.dz; mul_b = item_q.wx; end
			3'd3:    begin mul_a = item_q.dx; mul_b = item_q.wz; end
			3'd4:    begin mul_a = item_q.dx; mul_b = item_q.wy; end
			default: begin mul_a = item_q.dy; mul_b = item_q.wx; end
		endcase
	end
	assign prod = mul_a * mul_b;

	assign ld_idx = ((state_q == ST_DIV) && (comp_q != 2'd2)) ? comp_q + 2'd1 : 2'd0;
	assign c_sel = c_q[ld_idx];
	assign c_mag = c_sel[CW-1] ? MW'(-c_sel) : c_sel[MW-1:0];

	assign div_sh = {rem_q, n_q[NW-1]};
	assign div_ge = (div_sh >= {1'b0, den_q});
	assign huge_all = huge_q | q_q[VEL_W-1] | q_q[VEL_W-2];
	assign q_mag = {q_q[VEL_W-3:0], div_ge};

	always_comb begin
		if ((den_q == '0) || czero_q) begin
			term = '0;
		end else if (cpos_q) begin
			term = huge_all ? SAT_MIN : -$signed({1'b0, q_mag});
		end else begin
			term = huge_all ? SAT_MAX : $signed({1'b0, q_mag});
		end
		sum_wide = {sum_q[comp_q][VEL_W-1], sum_q[comp_q]} + {term[VEL_W-1], term};
		if (sum_wide[VEL_W] != sum_wide[VEL_W-1]) begin
			sum_new = sum_wide[VEL_W] ? SAT_MIN : SAT_MAX;
		end else begin
			sum_new = sum_wide[VEL_W-1:0];
		end
	end

	assign last_step = (cnt_q == CNTW'(NW - 1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q <= '0;
			comp_q <= '0;
			out_valid_q <= 1'b0;
			sum_q[0] <= '0;
			sum_q[1] <= '0;
			sum_q[2] <= '0;
		end else begin
			if ((state_q == ST_EMIT) && (!out_valid_q || pop)) begin
				out_valid_q <= 1'b1;
			end else if (pop && out_valid_q) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (item_valid) begin
						if (item.first) begin
							sum_q[0] <= '0;
							sum_q[1] <= '0;
							sum_q[2] <= '0;
						end
						cnt_q <= '0;
						state_q <= ST_SQ;
					end
				end
				ST_SQ: begin
					if (cnt_q == CNTW'(2)) begin
						cnt_q <= '0;
						state_q <= ST_SQRT;
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				ST_SQRT, ST_MUL: begin
					if (cnt_q == CNTW'(SW - 1)) begin
						cnt_q <= '0;
						state_q <= (state_q == ST_SQRT) ? ST_MUL : ST_CROSS;
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				ST_CROSS: begin
					if (cnt_q == CNTW'(5)) begin
						cnt_q <= '0;
						comp_q <= '0;
						state_q <= ST_DIV;
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				ST_DIV: begin
					if (last_step) begin
						sum_q[comp_q] <= sum_new;
						cnt_q <= '0;
						if (comp_q == 2'd2) begin
							state_q <= item_q.last ? ST_EMIT : ST_IDLE;
						end else begin
							comp_q <= comp_q + 2'd1;
						end
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				ST_EMIT: begin
					if (!out_valid_q || pop) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (item_valid) begin
					item_q <= item;
					r2_q <= R2W'(smoothing_sq) << FRAC_BITS;
				end
			end
			ST_SQ: begin
				r2_q <= r2_next;
				if (cnt_q == CNTW'(2)) begin
					x_q <= XPW'(r2_next) << (2 * FRAC_BITS);
					root_q <= '0;
					srem_q <= '0;
				end
			end
			ST_SQRT: begin
				x_q <= x_q << 2;
				if (srt_sh >= srt_trial) begin
					srem_q <= (SW+2)'(srt_sh - srt_trial);
					root_q <= {root_q[SW-2:0], 1'b1};
				end else begin
					srem_q <= srt_sh[SW+1:0];
					root_q <= {root_q[SW-2:0], 1'b0};
				end
				den_q <= '0;
			end
			ST_MUL: begin
				den_q <= (den_q << 1) + (root_q[SW-1] ? DENW'(r2_q) : '0);
				root_q <= root_q << 1;
			end
			ST_CROSS: begin
				if (!cnt_q[0]) begin
					p1_q <= prod;
				end else begin
					c_q[cnt_q[2:1]] <= {p1_q[64], p1_q} - {prod[64], prod};
				end
				if (cnt_q == CNTW'(5)) begin
					n_q <= {c_mag, {(3 * FRAC_BITS){1'b0}}};
					rem_q <= '0;
					q_q <= '0;
					huge_q <= 1'b0;
					cpos_q <= !c_sel[CW-1] && (c_sel != '0);
					czero_q <= (c_sel == '0);
				end
			end
			ST_DIV: begin
				if (last_step) begin
					n_q <= {c_mag, {(3 * FRAC_BITS){1'b0}}};
					rem_q <= '0;
					q_q <= '0;
					huge_q <= 1'b0;
					cpos_q <= !c_sel[CW-1] && (c_sel != '0);
					czero_q <= (c_sel == '0);
				end else begin
					n_q <= n_q << 1;
					rem_q <= div_ge ? DENW'(div_sh - {1'b0, den_q}) : div_sh[DENW-1:0];
					q_q <= {q_q[VEL_W-2:0], div_ge};
					huge_q <= huge_q | q_q[VEL_W-1];
				end
			end
			ST_EMIT: begin
				if (!out_valid_q || pop) begin
					vel_q[0] <= sum_q[0];
					vel_q[1] <= sum_q[1];
					vel_q[2] <= sum_q[2];
				end
			end
			default: begin
			end
		endcase
	end

endmodule

// ----- sv/regularized_biot_savart_sum.sv -----
// Accumulates the regularized Biot-Savart velocity that a run of sources induces at a target.
// Items enter through a difference stage and a two-entry queue; the back end then takes one
// item at a time and works through it in its squaring, square root, multiply, cross-product
// and division states. SW is the width of the radius square root (57 at FRAC_BITS = 24); the
// back end's running time is set by the bit-serial square root, the shift-add denominator
// multiply and the three bit-serial divisions that share one sequencer. An item carrying the
// last mark then emits its result, which waits in an output register until it is popped; the
// back end stalls there while an earlier result has not yet been popped.
module regularized_biot_savart_sum
	import rbs_pkg::*;
#(
	parameter int FRAC_BITS = 24
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      smoothing_sq_we,
	input  logic [31:0]               smoothing_sq,
	input  logic                      push,
	output logic                      full,
	input  logic signed [COORD_W-1:0] target_x,
	input  logic signed [COORD_W-1:0] target_y,
	input  logic signed [COORD_W-1:0] target_z,
	input  logic signed [COORD_W-1:0] src_x,
	input  logic signed [COORD_W-1:0] src_y,
	input  logic signed [COORD_W-1:0] src_z,
	input  logic signed [COORD_W-1:0] weight_x,
	input  logic signed [COORD_W-1:0] weight_y,
	input  logic signed [COORD_W-1:0] weight_z,
	input  logic                      first_source,
	input  logic                      last_source,
	output logic                      empty,
	input  logic                      pop,
	output logic signed [VEL_W-1:0]   vel_x,
	output logic signed [VEL_W-1:0]   vel_y,
	output logic signed [VEL_W-1:0]   vel_z
);

	logic [31:0] smoothing_sq_q;
	logic        f_valid;
	item_t       f_item;
	logic        f_ready;
	logic        q_valid;
	item_t       q_item;
	logic        q_take;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			smoothing_sq_q <= SMOOTHING_SQ_RESET;
		end else if (smoothing_sq_we) begin
			smoothing_sq_q <= smoothing_sq;
		end
	end

	rbs_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.push         (push),
		.full         (full),
		.target_x     (target_x),
		.target_y     (target_y),
		.target_z     (target_z),
		.src_x        (src_x),
		.src_y        (src_y),
		.src_z        (src_z),
		.weight_x     (weight_x),
		.weight_y     (weight_y),
		.weight_z     (weight_z),
		.first_source (first_source),
		.last_source  (last_source),
		.item_valid   (f_valid),
		.item         (f_item),
		.item_ready   (f_ready)
	);

	rbs_fifo u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_valid (f_valid),
		.wr_ready (f_ready),
		.wr_data  (f_item),
		.rd_valid (q_valid),
		.rd_take  (q_take),
		.rd_data  (q_item)
	);

	rbs_back #(
		.FRAC_BITS (FRAC_BITS)
	) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.smoothing_sq (smoothing_sq_q),
		.item_valid   (q_valid),
		.item         (q_item),
		.item_take    (q_take),
		.empty        (empty),
		.pop          (pop),
		.vel_x        (vel_x),
		.vel_y        (vel_y),
		.vel_z        (vel_z)
	);

endmodule
